[design/ilid_pkg.sv]
// Shared constants, codes and types for the indexed list block.
// No dependencies; imported by every other design file.
package ilid_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int DATA_W   = 32;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FRONT  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_END    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_AT     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // one memory access slot: a write and a read per cycle
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

endpackage

[design/indexed_list_insert_delete_top.sv]
// Indexed ordered list with insert and delete, one storage port pair.
// A read waits for the registered storage read. Appends, deletes of the last entry
// and errors finish from idle; other inserts shift the tail up one entry per cycle
// and then write the value; other deletes shift it down one entry per cycle. A new
// request is taken only when idle; busy drops as done is raised. Receiver cannot
// stall results. Sync reset clears count and sequencer, not storage contents.
module indexed_list_insert_delete_top import ilid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [ACT_W-1:0]         action,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     done,
  output logic signed [DATA_W-1:0] read_value,
  output logic [STAT_W-1:0]        status,
  output logic [LEN_W-1:0]         length
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDW  = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_INSW = 3'd3;
  localparam logic [2:0] S_SHDN = 3'd4;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [2:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] tgt;
  logic [DATA_W-1:0] ins_val;

  store_req_t        req;
  logic [DATA_W-1:0] rd_data;

  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  ins_pos;
  logic              is_ins;
  logic              pos_ok;
  logic              ins_range;
  logic              full;
  logic              up_last;
  logic              dn_last;

  ilid_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign busy   = (state != S_IDLE);
  assign length = LEN_W'(cnt);

  always_comb begin
    pos_ext   = CMP_W'(position);
    cnt_ext   = CMP_W'(cnt);
    is_ins    = (action == ACT_FRONT) || (action == ACT_END) || (action == ACT_AT);
    case (action)
      ACT_FRONT: ins_pos = '0;
      ACT_END:   ins_pos = cnt_ext;
      default:   ins_pos = pos_ext;
    endcase
    pos_ok    = pos_ext < cnt_ext;
    ins_range = ins_pos > cnt_ext;
    full      = (cnt == CAP_CNT);
    up_last   = (ptr - ADDR_W'(1)) == tgt;
    dn_last   = (CNT_W'(ptr) + CNT_W'(2)) == cnt;
  end

  // storage port drive per sequencer step
  always_comb begin
    req = '0;
    unique case (state)
      S_IDLE: begin
        if (action == ACT_DELETE) begin
          req.rd_addr = ADDR_W'(position + POS_W'(1));
        end else if (is_ins) begin
          if (ins_pos == cnt_ext) begin
            req.wr_en   = start && !ins_range && !full;
            req.wr_addr = ADDR_W'(ins_pos);
            req.wr_data = value;
          end
          req.rd_addr = ADDR_W'(cnt - CNT_W'(1));
        end else begin
          req.rd_addr = ADDR_W'(position);
        end
      end
      S_SHUP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = ptr;
        req.wr_data = rd_data;
        req.rd_addr = ptr - ADDR_W'(2);
      end
      S_INSW: begin
        req.wr_en   = 1'b1;
        req.wr_addr = tgt;
        req.wr_data = ins_val;
      end
      S_SHDN: begin
        req.wr_en   = 1'b1;
        req.wr_addr = ptr;
        req.wr_data = rd_data;
        req.rd_addr = ADDR_W'(CNT_W'(ptr) + CNT_W'(2));
      end
      S_RDW: begin
        req = '0;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            read_value <= '0;
            status     <= ST_DONE;
            if (action == ACT_READ) begin
              if (pos_ok) begin
                state <= S_RDW;
              end else begin
                read_value <= '1;
                status     <= ST_RANGE;
                done       <= 1'b1;
              end
            end else if (is_ins) begin
              ins_val <= value;
              tgt     <= ADDR_W'(ins_pos);
              ptr     <= ADDR_W'(cnt);
              if (ins_range) begin
                status <= ST_RANGE;
                done   <= 1'b1;
              end else if (full) begin
                status <= ST_FULL;
                done   <= 1'b1;
              end else if (ins_pos == cnt_ext) begin
                // append: written this cycle
                cnt  <= cnt + CNT_W'(1);
                done <= 1'b1;
              end else begin
                state <= S_SHUP;
              end
            end else if (action == ACT_DELETE) begin
              ptr <= ADDR_W'(position);
              if (!pos_ok) begin
                status <= ST_RANGE;
                done   <= 1'b1;
              end else if (pos_ext + CMP_W'(1) == cnt_ext) begin
                cnt  <= cnt - CNT_W'(1);
                done <= 1'b1;
              end else begin
                state <= S_SHDN;
              end
            end else begin
              status <= ST_RANGE;
              done   <= 1'b1;
            end
          end
        end
        S_RDW: begin
          read_value <= rd_data;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        S_SHUP: begin
          ptr <= ptr - ADDR_W'(1);
          if (up_last) begin
            state <= S_INSW;
          end
        end
        S_INSW: begin
          cnt   <= cnt + CNT_W'(1);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_SHDN: begin
          ptr <= ptr + ADDR_W'(1);
          if (dn_last) begin
            cnt   <= cnt - CNT_W'(1);
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/ilid_store.sv]
// List storage: one write port and one registered read port.
// Depends on ilid_pkg.
module ilid_store import ilid_pkg::*; (
  input  logic              clk,
  input  store_req_t        req,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for indexed_list_insert_delete_top: random and directed list requests,
// a queue-based list predictor in a scoreboard class, one result beat checked per request.
// Depends on ilid_pkg and the design top only.
`timescale 1ns / 1ps

module tb_top;
  import ilid_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 50;
  localparam int DRAIN_CYCLES   = 80;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] list_q[$];
    list_result_t             expected_q[$];
    int unsigned              errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int fill();
      return list_q.size();
    endfunction

    function logic [STAT_W-1:0] insert_entry(int p, logic signed [DATA_W-1:0] v);
      // range check wins over the full check
      if (p > list_q.size()) return ST_RANGE;
      if (list_q.size() >= CAPACITY) return ST_FULL;
      list_q.insert(p, v);
      return ST_DONE;
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      list_result_t r;
      int p;
      p = int'(pos);
      r.read_value = '0;
      r.status = ST_DONE;
      case (act)
        ACT_READ: begin
          if (p < list_q.size()) begin
            r.read_value = list_q[p];
          end else begin
            r.read_value = -1;
            r.status = ST_RANGE;
          end
        end
        ACT_FRONT:  r.status = insert_entry(0, val);
        ACT_END:    r.status = insert_entry(list_q.size(), val);
        ACT_AT:     r.status = insert_entry(p, val);
        ACT_DELETE: begin
          if (p < list_q.size()) list_q.delete(p);
          else r.status = ST_RANGE;
        end
        default: r.status = ST_RANGE;
      endcase
      r.length = LEN_W'(list_q.size());
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] rd, logic [STAT_W-1:0] st,
                               logic [LEN_W-1:0] len);
      list_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result beat: rd=%0d st=%0d len=%0d", rd, st, len);
        return;
      end
      e = expected_q.pop_front();
      if (rd !== e.read_value || st !== e.status || len !== e.length) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: expected rd=%0d st=%0d len=%0d, got rd=%0d st=%0d len=%0d",
                   e.read_value, e.status, e.length, rd, st, len);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [ACT_W-1:0]         action = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     done;
  logic signed [DATA_W-1:0] read_value;
  logic [STAT_W-1:0]        status;
  logic [LEN_W-1:0]         length;

  list_scoreboard board;
  int idle_pct = 0;
  int quiet_cycles = 0;
  bit filling = 1'b1;

  always #2 clk = ~clk;

  indexed_list_insert_delete_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .position  (position),
    .value     (value),
    .done      (done),
    .read_value(read_value),
    .status    (status),
    .length    (length)
  );

  // result beats cannot be held off: check every strobe
  always @(posedge clk) begin
    if (!rst && done === 1'b1) board.check_result(read_value, status, length);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((start && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    position <= pos;
    value <= val;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_request(act, pos, val);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    logic [ACT_W-1:0]         act;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int cnt;
    int r;
    cnt = board.fill();
    // fill to capacity, then drain to empty, and repeat
    if (filling && cnt == CAPACITY && $urandom_range(5) == 0) filling = 1'b0;
    if (!filling && cnt == 0) filling = 1'b1;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 18)      act = ACT_READ;
      else if (r < 34) act = ACT_FRONT;
      else if (r < 54) act = ACT_END;
      else if (r < 80) act = ACT_AT;
      else if (r < 94) act = ACT_DELETE;
      else             act = ACT_W'($urandom_range(5, 7));
    end else begin
      if (r < 20)      act = ACT_READ;
      else if (r < 26) act = ACT_FRONT;
      else if (r < 32) act = ACT_END;
      else if (r < 40) act = ACT_AT;
      else if (r < 94) act = ACT_DELETE;
      else             act = ACT_W'($urandom_range(5, 7));
    end
    r = $urandom_range(99);
    if (r < 80)      pos = POS_W'($urandom_range(0, cnt));
    else if (r < 90) pos = POS_W'(cnt + 1);
    else             pos = POS_W'($urandom_range(0, 127));
    r = $urandom_range(99);
    if (r < 80) begin
      val = $urandom;
    end else begin
      case ($urandom_range(3))
        0: val = 32'sh0000_0000;
        1: val = -32'sd1;
        2: val = 32'sh8000_0000;
        default: val = 32'sh7FFF_FFFF;
      endcase
    end
    send_request(act, pos, val);
  endtask

  task automatic run_phase(input int pct, input int items);
    idle_pct = pct;
    repeat (items) send_random_request();
    wait_all_results();
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, bounds, extremes, unknown actions
    send_request(ACT_READ, 7'd0, 32'sd0);
    send_request(ACT_DELETE, 7'd0, 32'sd0);
    send_request(ACT_AT, 7'd1, 32'sd5);
    send_request(ACT_AT, 7'd127, 32'sd6);
    send_request(ACT_AT, 7'd0, 32'sh7FFF_FFFF);
    send_request(ACT_FRONT, 7'd127, 32'sh8000_0000);
    send_request(ACT_END, 7'd127, -32'sd1);
    send_request(ACT_END, 7'd0, 32'sd0);
    send_request(ACT_AT, 7'd2, 32'sh5A5A_5A5A);
    send_request(ACT_AT, 7'd5, 32'sh1234_5678);   // position equal to count: append
    send_request(ACT_READ, 7'd0, 32'sd0);
    send_request(ACT_READ, 7'd2, 32'sd0);
    send_request(ACT_READ, 7'd5, -32'sd1);
    send_request(ACT_READ, 7'd6, 32'sd0);
    send_request(ACT_READ, 7'd127, 32'sd0);
    send_request(ACT_W'(5), 7'd0, 32'sd1);
    send_request(ACT_W'(6), 7'd3, -32'sd1);
    send_request(ACT_W'(7), 7'd127, 32'sh8000_0000);
    send_request(ACT_DELETE, 7'd0, 32'sd0);
    send_request(ACT_DELETE, 7'd4, 32'sd0);
    send_request(ACT_DELETE, 7'd1, 32'sd0);
    send_request(ACT_DELETE, 7'd3, 32'sd0);
    send_request(ACT_READ, 7'd1, 32'sd0);
    wait_all_results();

    run_phase(0, 380);
    run_phase(60, 300);
    run_phase(28, 300);
    run_phase(0, 170);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
